// ===== design/dtc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_pkg - trouble code table types and constants
// Item kinds, sequencer states, status byte bits and the stored entry layout.
// ----------------------------------------------------------------------------
package dtc_pkg;

   localparam int CODE_W   = 24;
   localparam int STATUS_W = 8;
   localparam int FAIL_W   = 2;
   localparam int KIND_W   = 3;
   localparam int MAXR_W   = 7;
   localparam int COUNT_W  = 7;
   localparam int LIM_W    = 5;
   localparam int ENTRY_W  = CODE_W + STATUS_W + FAIL_W;

   localparam logic [LIM_W-1:0]    MAX_RESULTS   = 5'd16;
   localparam logic [FAIL_W-1:0]   FAIL_CONFIRM  = 2'd2;
   localparam logic [FAIL_W-1:0]   FAIL_MAX      = 2'd3;
   localparam logic [STATUS_W-1:0] ABSENT_STATUS = 8'h00;

   localparam logic [STATUS_W-1:0] ST_FAILED             = 8'h01;
   localparam logic [STATUS_W-1:0] ST_FAILED_CYCLE       = 8'h02;
   localparam logic [STATUS_W-1:0] ST_PENDING            = 8'h04;
   localparam logic [STATUS_W-1:0] ST_CONFIRMED          = 8'h08;
   localparam logic [STATUS_W-1:0] ST_NC_SINCE_CLEAR     = 8'h10;
   localparam logic [STATUS_W-1:0] ST_FAILED_SINCE_CLEAR = 8'h20;
   localparam logic [STATUS_W-1:0] ST_NC_CYCLE           = 8'h40;
   localparam logic [STATUS_W-1:0] ST_WARNING            = 8'h80;

   typedef enum logic [KIND_W-1:0] {
      KIND_SET_FAILED   = 3'd0,
      KIND_CLEAR_FAILED = 3'd1,
      KIND_CLEAR_ALL    = 3'd2,
      KIND_QUERY        = 3'd3,
      KIND_REPORT       = 3'd4,
      KIND_COUNT        = 3'd5,
      KIND_DRIVE_CYCLE  = 3'd6
   } kind_type;

   typedef enum logic [1:0] {
      SEQ_IDLE   = 2'd0,
      SEQ_READ   = 2'd1,
      SEQ_EVAL   = 2'd2,
      SEQ_FINISH = 2'd3
   } state_type;

   typedef struct packed {
      logic [CODE_W-1:0]   code;
      logic [STATUS_W-1:0] status;
      logic [FAIL_W-1:0]   fail_count;
   } entry_type;

endpackage
`default_nettype wire

// ===== design/dtc_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_if - request and response channels
// Valid/ready channels carrying one request or one response transaction.
// ----------------------------------------------------------------------------
interface dtc_req_if;
   logic                              valid;
   logic                              ready;
   logic [dtc_pkg::KIND_W-1:0]        kind;
   logic [dtc_pkg::CODE_W-1:0]        dtc_code;
   logic [dtc_pkg::STATUS_W-1:0]      status_mask;
   logic [dtc_pkg::MAXR_W-1:0]        max_reports;
   logic                              cycle_done;

   modport source (output valid, kind, dtc_code, status_mask, max_reports, cycle_done,
                   input ready);
   modport sink   (input valid, kind, dtc_code, status_mask, max_reports, cycle_done,
                   output ready);
endinterface

interface dtc_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [dtc_pkg::CODE_W-1:0]        code_out;
   logic [dtc_pkg::STATUS_W-1:0]      status_out;
   logic [dtc_pkg::COUNT_W-1:0]       match_count;
   logic                              found;
   logic                              table_full;
   logic                              last;

   modport source (output valid, code_out, status_out, match_count, found, table_full, last,
                   input ready);
   modport sink   (input valid, code_out, status_out, match_count, found, table_full, last,
                   output ready);
endinterface
`default_nettype wire

// ===== design/diagnostic_trouble_code_table_top.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// diagnostic_trouble_code_table_top - trouble code table with status bytes
// Stores trouble codes with status bytes and fail counters; one comparator
// walks the entry RAM for lookups, reports, counts and drive-cycle updates.
// ----------------------------------------------------------------------------
//  channel  | direction | handshake     | transaction
//  req_ch   | in        | valid / ready | kind, code, mask, report limit, cycle done
//  rsp_ch   | out       | valid / ready | code, status, count, found, full, last
//
//  Walking items (set, clear failed, query, report, count, drive cycle done)
//  read each entry in SEQ_READ and evaluate it in SEQ_EVAL on the single
//  registered read port; other items go straight to SEQ_FINISH.
//  Reports stop early once the limit is reached and stall while a previous
//  result waits on rsp_ch. req_ch.ready is high only between transactions.
//  Synchronous reset frees all entries at once through the valid bits.
// ----------------------------------------------------------------------------
module diagnostic_trouble_code_table_top #(
   parameter int NUM_ENTRIES = 16
) (
   input  wire logic  clock,
   input  wire logic  reset,
   dtc_req_if.sink    req_ch,
   dtc_rsp_if.source  rsp_ch
);

   localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

   typedef struct packed {
      logic [dtc_pkg::CODE_W-1:0]   code;
      logic [dtc_pkg::STATUS_W-1:0] status;
      logic [dtc_pkg::COUNT_W-1:0]  count;
      logic                         found;
      logic                         full;
      logic                         last;
   } rsp_word_type;

   dtc_pkg::state_type             state_ff, state_in;
   logic [IDX_W-1:0]               idx_ff, idx_in;
   dtc_pkg::kind_type              kind_ff, kind_in;
   logic [dtc_pkg::CODE_W-1:0]     code_ff, code_in;
   logic [dtc_pkg::STATUS_W-1:0]   mask_ff, mask_in;
   logic [dtc_pkg::LIM_W-1:0]      lim_ff, lim_in;
   logic                           hit_ff, hit_in;
   logic [IDX_W-1:0]               hit_idx_ff, hit_idx_in;
   dtc_pkg::entry_type             hit_entry_ff, hit_entry_in;
   logic                           free_ff, free_in;
   logic [IDX_W-1:0]               free_idx_ff, free_idx_in;
   logic [dtc_pkg::COUNT_W-1:0]    cnt_ff, cnt_in;
   logic                           pend_valid_ff, pend_valid_in;
   logic [dtc_pkg::CODE_W-1:0]     pend_code_ff, pend_code_in;
   logic [dtc_pkg::STATUS_W-1:0]   pend_status_ff, pend_status_in;
   logic [NUM_ENTRIES-1:0]         valid_ff, valid_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   rsp_word_type                   rsp_ff, rsp_word;

   logic                           emit;
   logic                           can_emit;
   logic                           req_accept;
   dtc_pkg::kind_type              req_kind;
   logic [dtc_pkg::LIM_W-1:0]      lim_req;
   logic                           start_scan;

   logic                           wr_en;
   logic [IDX_W-1:0]               wr_addr;
   dtc_pkg::entry_type             wr_data;
   dtc_pkg::entry_type             rd_entry;
   logic [dtc_pkg::ENTRY_W-1:0]    rd_word;

   logic                           cur_valid;
   logic                           code_hit;
   logic                           mask_hit;
   logic                           is_report;
   logic                           rep_take;
   logic                           rep_stall;
   logic                           rep_full;
   logic                           scan_end;

   logic [IDX_W-1:0]               set_slot;
   dtc_pkg::entry_type             set_base;
   logic [dtc_pkg::FAIL_W-1:0]     set_fail;
   logic [dtc_pkg::STATUS_W-1:0]   set_raw;
   logic [dtc_pkg::STATUS_W-1:0]   set_status;
   logic [dtc_pkg::STATUS_W-1:0]   clr_status;
   logic [dtc_pkg::STATUS_W-1:0]   drv_raw;
   dtc_pkg::entry_type             drv_entry;

   dtc_ram #(
      .WIDTH (dtc_pkg::ENTRY_W),
      .DEPTH (NUM_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (idx_ff),
      .rd_data (rd_word)
   );

   assign rd_entry   = dtc_pkg::entry_type'(rd_word);

   assign req_ch.ready = (state_ff == dtc_pkg::SEQ_IDLE);
   assign req_accept   = req_ch.valid && req_ch.ready;
   assign can_emit     = !rsp_valid_ff || rsp_ch.ready;

   assign req_kind = dtc_pkg::kind_type'(req_ch.kind);
   assign lim_req  = (req_ch.max_reports > dtc_pkg::MAXR_W'(dtc_pkg::MAX_RESULTS)) ?
                     dtc_pkg::MAX_RESULTS : req_ch.max_reports[dtc_pkg::LIM_W-1:0];

   always_comb begin
      case (req_kind)
         dtc_pkg::KIND_SET_FAILED:   start_scan = (req_ch.dtc_code != '0);
         dtc_pkg::KIND_CLEAR_FAILED: start_scan = 1'b1;
         dtc_pkg::KIND_QUERY:        start_scan = 1'b1;
         dtc_pkg::KIND_REPORT:       start_scan = (lim_req != '0);
         dtc_pkg::KIND_COUNT:        start_scan = 1'b1;
         dtc_pkg::KIND_DRIVE_CYCLE:  start_scan = req_ch.cycle_done;
         default:                    start_scan = 1'b0;
      endcase
   end

   // scan decode
   assign cur_valid = valid_ff[idx_ff];
   assign code_hit  = cur_valid && (rd_entry.code == code_ff);
   assign mask_hit  = cur_valid && ((rd_entry.status & mask_ff) != '0);
   assign is_report = (kind_ff == dtc_pkg::KIND_REPORT);
   assign rep_take  = is_report && mask_hit && (!pend_valid_ff || can_emit);
   assign rep_stall = is_report && mask_hit && pend_valid_ff && !can_emit;
   assign rep_full  = rep_take &&
                      ((cnt_ff + dtc_pkg::COUNT_W'(1)) == dtc_pkg::COUNT_W'(lim_ff));
   assign scan_end  = (idx_ff == LAST_IDX) || rep_full;

   // set failed update
   assign set_slot = hit_ff ? hit_idx_ff : free_idx_ff;
   assign set_base = hit_ff ? hit_entry_ff : '0;
   assign set_fail = (set_base.fail_count == dtc_pkg::FAIL_MAX) ?
                     dtc_pkg::FAIL_MAX : set_base.fail_count + dtc_pkg::FAIL_W'(1);
   assign set_raw  = (set_base.status | dtc_pkg::ST_FAILED | dtc_pkg::ST_FAILED_CYCLE |
                      dtc_pkg::ST_PENDING | dtc_pkg::ST_FAILED_SINCE_CLEAR) &
                     ~dtc_pkg::ST_NC_CYCLE;
   assign set_status = (set_fail >= dtc_pkg::FAIL_CONFIRM) ?
                       (set_raw | dtc_pkg::ST_CONFIRMED | dtc_pkg::ST_WARNING) : set_raw;

   assign clr_status = hit_entry_ff.status &
                       ~(dtc_pkg::ST_FAILED | dtc_pkg::ST_FAILED_CYCLE);

   // drive cycle update
   assign drv_raw = (rd_entry.status & ~(dtc_pkg::ST_FAILED_CYCLE | dtc_pkg::ST_NC_CYCLE)) |
                    dtc_pkg::ST_NC_SINCE_CLEAR;
   always_comb begin
      drv_entry = rd_entry;
      drv_entry.status = drv_raw;
      if ((drv_raw & dtc_pkg::ST_FAILED) == '0) begin
         drv_entry.status     = drv_raw & ~dtc_pkg::ST_PENDING;
         drv_entry.fail_count = '0;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         dtc_pkg::SEQ_IDLE: begin
            if (req_accept) begin
               state_in = start_scan ? dtc_pkg::SEQ_READ : dtc_pkg::SEQ_FINISH;
            end
         end
         dtc_pkg::SEQ_READ: begin
            state_in = dtc_pkg::SEQ_EVAL;
         end
         dtc_pkg::SEQ_EVAL: begin
            if (!rep_stall) begin
               state_in = scan_end ? dtc_pkg::SEQ_FINISH : dtc_pkg::SEQ_READ;
            end
         end
         dtc_pkg::SEQ_FINISH: begin
            if (can_emit) begin
               state_in = dtc_pkg::SEQ_IDLE;
            end
         end
         default: begin
            state_in = dtc_pkg::SEQ_IDLE;
         end
      endcase
   end

   // datapath and outputs
   always_comb begin
      idx_in         = idx_ff;
      kind_in        = kind_ff;
      code_in        = code_ff;
      mask_in        = mask_ff;
      lim_in         = lim_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_entry_in   = hit_entry_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      cnt_in         = cnt_ff;
      pend_valid_in  = pend_valid_ff;
      pend_code_in   = pend_code_ff;
      pend_status_in = pend_status_ff;
      valid_in       = valid_ff;
      emit           = 1'b0;
      rsp_word       = '0;
      rsp_word.last  = 1'b1;
      wr_en          = 1'b0;
      wr_addr        = idx_ff;
      wr_data        = drv_entry;

      case (state_ff)
         dtc_pkg::SEQ_IDLE: begin
            if (req_accept) begin
               kind_in       = req_kind;
               code_in       = req_ch.dtc_code;
               mask_in       = req_ch.status_mask;
               lim_in        = lim_req;
               idx_in        = '0;
               hit_in        = 1'b0;
               free_in       = 1'b0;
               cnt_in        = '0;
               pend_valid_in = 1'b0;
            end
         end
         dtc_pkg::SEQ_READ: begin
         end
         dtc_pkg::SEQ_EVAL: begin
            case (kind_ff)
               dtc_pkg::KIND_SET_FAILED,
               dtc_pkg::KIND_CLEAR_FAILED,
               dtc_pkg::KIND_QUERY: begin
                  if (code_hit && !hit_ff) begin
                     hit_in       = 1'b1;
                     hit_idx_in   = idx_ff;
                     hit_entry_in = rd_entry;
                  end
                  if (!cur_valid && !free_ff) begin
                     free_in     = 1'b1;
                     free_idx_in = idx_ff;
                  end
               end
               dtc_pkg::KIND_COUNT: begin
                  if (mask_hit) begin
                     cnt_in = cnt_ff + dtc_pkg::COUNT_W'(1);
                  end
               end
               dtc_pkg::KIND_REPORT: begin
                  if (rep_take) begin
                     if (pend_valid_ff) begin
                        emit            = 1'b1;
                        rsp_word.code   = pend_code_ff;
                        rsp_word.status = pend_status_ff;
                        rsp_word.found  = 1'b1;
                        rsp_word.last   = 1'b0;
                     end
                     pend_valid_in  = 1'b1;
                     pend_code_in   = rd_entry.code;
                     pend_status_in = rd_entry.status;
                     cnt_in         = cnt_ff + dtc_pkg::COUNT_W'(1);
                  end
               end
               dtc_pkg::KIND_DRIVE_CYCLE: begin
                  wr_en = cur_valid;
               end
               default: begin
               end
            endcase
            if (!rep_stall && !scan_end) begin
               idx_in = idx_ff + IDX_W'(1);
            end
         end
         dtc_pkg::SEQ_FINISH: begin
            if (can_emit) begin
               emit = 1'b1;
               case (kind_ff)
                  dtc_pkg::KIND_SET_FAILED: begin
                     if (code_ff != '0) begin
                        rsp_word.code = code_ff;
                        if (hit_ff || free_ff) begin
                           wr_en              = 1'b1;
                           wr_addr            = set_slot;
                           wr_data.code       = code_ff;
                           wr_data.status     = set_status;
                           wr_data.fail_count = set_fail;
                           valid_in[set_slot] = 1'b1;
                           rsp_word.status    = set_status;
                           rsp_word.found     = 1'b1;
                        end else begin
                           rsp_word.full = 1'b1;
                        end
                     end
                  end
                  dtc_pkg::KIND_CLEAR_FAILED: begin
                     rsp_word.code = code_ff;
                     if (hit_ff) begin
                        wr_en           = 1'b1;
                        wr_addr         = hit_idx_ff;
                        wr_data         = hit_entry_ff;
                        wr_data.status  = clr_status;
                        rsp_word.status = clr_status;
                        rsp_word.found  = 1'b1;
                     end else begin
                        rsp_word.status = dtc_pkg::ABSENT_STATUS;
                     end
                  end
                  dtc_pkg::KIND_CLEAR_ALL: begin
                     valid_in = '0;
                  end
                  dtc_pkg::KIND_QUERY: begin
                     rsp_word.code   = code_ff;
                     rsp_word.status = hit_ff ? hit_entry_ff.status : dtc_pkg::ABSENT_STATUS;
                     rsp_word.found  = hit_ff;
                  end
                  dtc_pkg::KIND_REPORT: begin
                     if (pend_valid_ff) begin
                        rsp_word.code   = pend_code_ff;
                        rsp_word.status = pend_status_ff;
                        rsp_word.found  = 1'b1;
                     end
                  end
                  dtc_pkg::KIND_COUNT: begin
                     rsp_word.count = cnt_ff;
                     rsp_word.found = (cnt_ff != '0);
                  end
                  default: begin
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid_in = emit ? 1'b1 : (rsp_ch.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= dtc_pkg::SEQ_IDLE;
         valid_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         valid_ff      <= valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff         <= idx_in;
      kind_ff        <= kind_in;
      code_ff        <= code_in;
      mask_ff        <= mask_in;
      lim_ff         <= lim_in;
      hit_ff         <= hit_in;
      hit_idx_ff     <= hit_idx_in;
      hit_entry_ff   <= hit_entry_in;
      free_ff        <= free_in;
      free_idx_ff    <= free_idx_in;
      cnt_ff         <= cnt_in;
      pend_code_ff   <= pend_code_in;
      pend_status_ff <= pend_status_in;
      if (emit) begin
         rsp_ff <= rsp_word;
      end
   end

   assign rsp_ch.valid       = rsp_valid_ff;
   assign rsp_ch.code_out    = rsp_ff.code;
   assign rsp_ch.status_out  = rsp_ff.status;
   assign rsp_ch.match_count = rsp_ff.count;
   assign rsp_ch.found       = rsp_ff.found;
   assign rsp_ch.table_full  = rsp_ff.full;
   assign rsp_ch.last        = rsp_ff.last;

endmodule
`default_nettype wire

// ===== design/dtc_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_ram - generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module dtc_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// ===== design/dtc_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// dtc_checker - port-level checks for the trouble code table
// Watches the request and response channels; bound to the top level.
// ----------------------------------------------------------------------------
module dtc_checker (
   input wire logic                             clock,
   input wire logic                             reset,
   input wire logic                             req_valid,
   input wire logic                             req_ready,
   input wire logic                             rsp_valid,
   input wire logic                             rsp_ready,
   input wire logic [dtc_pkg::CODE_W-1:0]       rsp_code_out,
   input wire logic [dtc_pkg::STATUS_W-1:0]     rsp_status_out,
   input wire logic [dtc_pkg::COUNT_W-1:0]      rsp_match_count,
   input wire logic                             rsp_found,
   input wire logic                             rsp_table_full,
   input wire logic                             rsp_last
);

   // held response transaction keeps its code, status, found and last fields
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_code_out) &&
      $stable(rsp_status_out) && $stable(rsp_last) && $stable(rsp_found))
      else $error("response changed while stalled");

   // one request transaction at a time
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while busy");

   a_full_not_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_found && rsp_table_full))
      else $error("table full flagged with found");

   // only report transactions span several responses, each a match
   a_mid_run_found: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_found && !rsp_table_full && rsp_match_count == '0)
      else $error("non-final response without a match");

   a_count_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_match_count != '0 |-> rsp_found && rsp_last &&
      rsp_code_out == '0)
      else $error("count response malformed");

endmodule

bind diagnostic_trouble_code_table_top dtc_checker u_dtc_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_ch.valid),
   .req_ready       (req_ch.ready),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .rsp_code_out    (rsp_ch.code_out),
   .rsp_status_out  (rsp_ch.status_out),
   .rsp_match_count (rsp_ch.match_count),
   .rsp_found       (rsp_ch.found),
   .rsp_table_full  (rsp_ch.table_full),
   .rsp_last        (rsp_ch.last)
);
`default_nettype wire
